FILE: sv/wvra_pkg.sv
// Shared types and constants for the windowed vibration range alarm.
// Used by the top level, wvra_axis and wvra_cfg; no dependencies of its own.
package wvra_pkg;

    localparam int AXIS_COUNT     = 3;
    localparam int MAG_W          = 16;
    localparam int HIT_W          = 16;
    localparam int LIMITS_W       = AXIS_COUNT * MAG_W;
    localparam int PERIOD_W       = 32;
    localparam int THRESH_W       = 16;
    localparam int DURATION_W     = 32;
    localparam int TICK_WIDTH_DEF = 32;
    localparam int NOW_W          = 32;
    localparam int APB_AW         = 6;
    localparam int APB_DW         = 64;

    localparam logic [HIT_W-1:0] HIT_MAX = '1;

    // Register index, taken from paddr[5:3]
    typedef enum logic [2:0] {
        REG_LOWER    = 3'd0,
        REG_UPPER    = 3'd1,
        REG_PERIOD   = 3'd2,
        REG_THRESH   = 3'd3,
        REG_DURATION = 3'd4,
        REG_AUTOSTOP = 3'd5
    } reg_idx_t;

    typedef enum logic [1:0] {
        OP_TICK   = 2'd0,
        OP_SAMPLE = 2'd1,
        OP_CANCEL = 2'd2,
        OP_POLICY = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EVAL,
        ST_DIV,
        ST_STOP,
        ST_SAMPLE,
        ST_APPLY,
        ST_RESP
    } state_t;

    typedef struct packed {
        logic [LIMITS_W-1:0]   lower_limits;
        logic [LIMITS_W-1:0]   upper_limits;
        logic [PERIOD_W-1:0]   window_period;
        logic [THRESH_W-1:0]   trigger_threshold;
        logic [DURATION_W-1:0] alarm_duration;
        logic                  auto_stop_enable;
    } cfg_t;

endpackage

FILE: sv/windowed_vibration_range_alarm.sv
// Top level of the windowed three-axis vibration range alarm: sequencer,
// alarm state and tick arithmetic. Depends on wvra_pkg, wvra_cfg,
// wvra_axis and wvra_rem.
//
//   channel | direction | handshake        | beat contents
//   --------+-----------+------------------+--------------------------------------
//   s_      | in        | s_valid/s_ready  | operation, now_ticks, magnitude_x/y/z
//   m_      | out       | m_valid/m_ready  | alarm_event, alarm_on, active_axes
//   apb     | in        | psel/penable     | paddr (reg at 8*i), pwdata/prdata 64b
//
// One beat at a time. After accept, a tick beat runs through EVAL and STOP,
// a sample beat also through SAMPLE, and both wait in DIV when a window
// closes: the origin realignment needs (elapsed mod period) from the
// bit-serial remainder unit. Cancel and policy beats go through APPLY.
// s_ready is high only when idle.
// A stalled m_ready holds the result and the sequencer; nothing is dropped.
// aresetn is synchronous; reset acts as init at tick 0.
module windowed_vibration_range_alarm #(
    parameter int TICK_WIDTH = wvra_pkg::TICK_WIDTH_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    // input channel
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [1:0]                  s_operation,
    input  logic [wvra_pkg::NOW_W-1:0]  s_now_ticks,
    input  logic [wvra_pkg::MAG_W-1:0]  s_magnitude_x,
    input  logic [wvra_pkg::MAG_W-1:0]  s_magnitude_y,
    input  logic [wvra_pkg::MAG_W-1:0]  s_magnitude_z,
    // result channel
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic                        m_alarm_event,
    output logic                        m_alarm_on,
    output logic [wvra_pkg::AXIS_COUNT-1:0] m_active_axes,
    // config port
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [wvra_pkg::APB_AW-1:0] paddr,
    input  logic [wvra_pkg::APB_DW-1:0] pwdata,
    output logic [wvra_pkg::APB_DW-1:0] prdata,
    output logic                        pready
);

    localparam int AX = wvra_pkg::AXIS_COUNT;
    localparam int MW = wvra_pkg::MAG_W;
    localparam int HW = wvra_pkg::HIT_W;
    // compares need room for both the tick and the 32-bit settings
    localparam int CMP_W = (TICK_WIDTH > wvra_pkg::PERIOD_W) ? TICK_WIDTH
                                                              : wvra_pkg::PERIOD_W;

    wvra_pkg::cfg_t cfg;

    wvra_pkg::state_t state_reg, state_next;
    wvra_pkg::op_t    op_reg, op_next;

    logic [TICK_WIDTH-1:0] now_reg, now_next;
    logic [TICK_WIDTH-1:0] win_org_reg, win_org_next;
    logic [TICK_WIDTH-1:0] alm_org_reg, alm_org_next;
    logic [MW-1:0]         mag_reg [AX];
    logic [MW-1:0]         mag_next [AX];
    logic [HW-1:0]         hit_reg [AX];
    logic [HW-1:0]         hit_next [AX];
    logic [HW-1:0]         hit_upd [AX];
    logic [AX-1:0]         latched_reg, latched_next;
    logic                  alarm_reg, alarm_next;
    logic                  changed_reg, changed_next;

    logic [wvra_pkg::PERIOD_W-1:0]   period_eff;
    logic [wvra_pkg::THRESH_W-1:0]   thresh_eff;
    logic [wvra_pkg::DURATION_W-1:0] dur_eff;
    logic [TICK_WIDTH-1:0]           elapsed;
    logic [TICK_WIDTH-1:0]           since_alarm;
    logic                            window_due;
    logic                            stop_due;
    logic [AX-1:0]                   reached;

    logic                  rem_start;
    logic                  rem_done;
    logic [TICK_WIDTH-1:0] rem_value;

    // ---------------- config registers ----------------
    wvra_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // zero settings act as one
    assign period_eff = (cfg.window_period == '0) ? wvra_pkg::PERIOD_W'(1)
                                                  : cfg.window_period;
    assign thresh_eff = (cfg.trigger_threshold == '0) ? wvra_pkg::THRESH_W'(1)
                                                      : cfg.trigger_threshold;
    assign dur_eff    = (cfg.alarm_duration == '0) ? wvra_pkg::DURATION_W'(1)
                                                   : cfg.alarm_duration;

    // ---------------- tick arithmetic ----------------
    assign elapsed     = now_reg - win_org_reg;
    assign since_alarm = now_reg - alm_org_reg;
    assign window_due  = CMP_W'(elapsed) >= CMP_W'(period_eff);
    assign stop_due    = alarm_reg && cfg.auto_stop_enable &&
                         (CMP_W'(since_alarm) >= CMP_W'(dur_eff));

    // ---------------- per-axis lanes ----------------
    for (genvar a = 0; a < AX; a++) begin : g_axis
        assign reached[a] = hit_reg[a] >= thresh_eff;

        wvra_axis u_axis (
            .magnitude (mag_reg[a]),
            .lo_limit  (cfg.lower_limits[a*MW +: MW]),
            .hi_limit  (cfg.upper_limits[a*MW +: MW]),
            .count_in  (hit_reg[a]),
            .count_out (hit_upd[a])
        );
    end

    // ---------------- window realignment remainder ----------------
    // origin += floor(elapsed/period)*period  ==  now - (elapsed mod period).
    // Runs only when elapsed >= period, so the period fits TICK_WIDTH here.
    wvra_rem #(
        .W (TICK_WIDTH)
    ) u_rem (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (rem_start),
        .dividend  (elapsed),
        .divisor   (TICK_WIDTH'(period_eff)),
        .done      (rem_done),
        .remainder (rem_value)
    );

    // ---------------- sequencer: next state ----------------
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            wvra_pkg::ST_IDLE: begin
                if (s_valid) begin
                    if (s_operation == wvra_pkg::OP_TICK ||
                        s_operation == wvra_pkg::OP_SAMPLE) begin
                        state_next = wvra_pkg::ST_EVAL;
                    end else begin
                        state_next = wvra_pkg::ST_APPLY;
                    end
                end
            end
            wvra_pkg::ST_EVAL: begin
                state_next = window_due ? wvra_pkg::ST_DIV : wvra_pkg::ST_STOP;
            end
            wvra_pkg::ST_DIV: begin
                if (rem_done) begin
                    state_next = wvra_pkg::ST_STOP;
                end
            end
            wvra_pkg::ST_STOP: begin
                state_next = (op_reg == wvra_pkg::OP_SAMPLE) ? wvra_pkg::ST_SAMPLE
                                                             : wvra_pkg::ST_RESP;
            end
            wvra_pkg::ST_SAMPLE: state_next = wvra_pkg::ST_RESP;
            wvra_pkg::ST_APPLY:  state_next = wvra_pkg::ST_RESP;
            wvra_pkg::ST_RESP: begin
                if (m_ready) begin
                    state_next = wvra_pkg::ST_IDLE;
                end
            end
            default: state_next = wvra_pkg::ST_IDLE;
        endcase
    end

    // ---------------- sequencer: outputs ----------------
    always_comb begin
        s_ready   = 1'b0;
        m_valid   = 1'b0;
        rem_start = 1'b0;
        unique case (state_reg)
            wvra_pkg::ST_IDLE: s_ready   = 1'b1;
            wvra_pkg::ST_EVAL: rem_start = window_due;
            wvra_pkg::ST_RESP: m_valid   = 1'b1;
            default: ;
        endcase
    end

    // ---------------- datapath next values ----------------
    always_comb begin
        op_next      = op_reg;
        now_next     = now_reg;
        win_org_next = win_org_reg;
        alm_org_next = alm_org_reg;
        latched_next = latched_reg;
        alarm_next   = alarm_reg;
        changed_next = changed_reg;
        for (int a = 0; a < AX; a++) begin
            mag_next[a] = mag_reg[a];
            hit_next[a] = hit_reg[a];
        end

        unique case (state_reg)
            wvra_pkg::ST_IDLE: begin
                if (s_valid) begin
                    op_next      = wvra_pkg::op_t'(s_operation);
                    now_next     = TICK_WIDTH'(s_now_ticks);
                    mag_next[0]  = s_magnitude_x;
                    mag_next[1]  = s_magnitude_y;
                    mag_next[2]  = s_magnitude_z;
                    changed_next = 1'b0;
                end
            end
            wvra_pkg::ST_EVAL: begin
                // window close: latch axes at or over threshold, clear counts
                if (window_due) begin
                    latched_next = latched_reg | reached;
                    if (|reached) begin
                        alarm_next = 1'b1;
                        if (!alarm_reg) begin
                            alm_org_next = now_reg;
                        end
                    end
                    changed_next = |(reached & ~latched_reg);
                    for (int a = 0; a < AX; a++) begin
                        hit_next[a] = '0;
                    end
                end
            end
            wvra_pkg::ST_DIV: begin
                if (rem_done) begin
                    win_org_next = now_reg - rem_value;
                end
            end
            wvra_pkg::ST_STOP: begin
                if (stop_due) begin
                    latched_next = '0;
                    alarm_next   = 1'b0;
                    alm_org_next = now_reg;
                    changed_next = 1'b1;
                end
            end
            wvra_pkg::ST_SAMPLE: begin
                for (int a = 0; a < AX; a++) begin
                    hit_next[a] = hit_upd[a];
                end
            end
            wvra_pkg::ST_APPLY: begin
                for (int a = 0; a < AX; a++) begin
                    hit_next[a] = '0;
                end
                win_org_next = now_reg;
                if (op_reg == wvra_pkg::OP_CANCEL) begin
                    changed_next = alarm_reg;
                    latched_next = '0;
                    alarm_next   = 1'b0;
                    alm_org_next = now_reg;
                end else if (alarm_reg && cfg.auto_stop_enable) begin
                    alm_org_next = now_reg;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= wvra_pkg::ST_IDLE;
            win_org_reg <= '0;
            alm_org_reg <= '0;
            latched_reg <= '0;
            alarm_reg   <= 1'b0;
            changed_reg <= 1'b0;
            for (int a = 0; a < AX; a++) begin
                hit_reg[a] <= '0;
            end
        end else begin
            state_reg   <= state_next;
            win_org_reg <= win_org_next;
            alm_org_reg <= alm_org_next;
            latched_reg <= latched_next;
            alarm_reg   <= alarm_next;
            changed_reg <= changed_next;
            for (int a = 0; a < AX; a++) begin
                hit_reg[a] <= hit_next[a];
            end
        end
        op_reg  <= op_next;
        now_reg <= now_next;
        for (int a = 0; a < AX; a++) begin
            mag_reg[a] <= mag_next[a];
        end
    end

    assign m_alarm_event = changed_reg;
    assign m_alarm_on    = alarm_reg;
    assign m_active_axes = latched_reg;

    // ---------------- assertions ----------------
    // never take a beat while a result is pending
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid))
        else $error("input accepted while result pending");

    // a latched axis always comes with the alarm on
    a_latch_needs_alarm: assert property (@(posedge aclk) disable iff (!aresetn)
        (|latched_reg) |-> alarm_reg)
        else $error("axis latched with alarm off");

    // remainder completes only while the sequencer waits for it
    a_rem_in_div: assert property (@(posedge aclk) disable iff (!aresetn)
        rem_done |-> (state_reg == wvra_pkg::ST_DIV))
        else $error("remainder done outside realignment");

    // one beat at a time
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("ready stayed high after accept");

endmodule

FILE: sv/wvra_rem.sv
// Serial restoring remainder unit: one quotient bit per cycle.
// Depends on nothing but its parameter.
module wvra_rem #(
    parameter int W = 32
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         start,
    input  logic [W-1:0] dividend,
    input  logic [W-1:0] divisor,
    output logic         done,
    output logic [W-1:0] remainder
);

    localparam int CW = $clog2(W + 1);

    logic [W-1:0]  num_reg, num_next;
    logic [W-1:0]  den_reg, den_next;
    logic [W-1:0]  rem_reg, rem_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [W:0]    trial;
    logic [W:0]    diff;

    assign trial = {rem_reg, num_reg[W-1]};
    assign diff  = trial - {1'b0, den_reg};

    always_comb begin
        num_next  = num_reg;
        den_next  = den_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            num_next  = dividend;
            den_next  = divisor;
            rem_next  = '0;
            cnt_next  = CW'(W);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            num_next = {num_reg[W-2:0], 1'b0};
            rem_next = (trial >= {1'b0, den_reg}) ? diff[W-1:0] : trial[W-1:0];
            cnt_next = cnt_reg - CW'(1);
            if (cnt_reg == CW'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        num_reg <= num_next;
        den_reg <= den_next;
        rem_reg <= rem_next;
    end

    assign done      = done_reg;
    assign remainder = rem_reg;

endmodule

FILE: sv/wvra_axis.sv
// One axis lane: range check of a magnitude and saturating hit count.
// Depends on wvra_pkg.
module wvra_axis (
    input  logic [wvra_pkg::MAG_W-1:0] magnitude,
    input  logic [wvra_pkg::MAG_W-1:0] lo_limit,
    input  logic [wvra_pkg::MAG_W-1:0] hi_limit,
    input  logic [wvra_pkg::HIT_W-1:0] count_in,
    output logic [wvra_pkg::HIT_W-1:0] count_out
);

    logic [wvra_pkg::MAG_W-1:0] lo_eff;
    logic                       outside;

    // crossed limits: lower clamps to upper
    assign lo_eff  = (lo_limit > hi_limit) ? hi_limit : lo_limit;
    assign outside = (magnitude < lo_eff) || (magnitude > hi_limit);

    always_comb begin
        count_out = count_in;
        if (outside && (count_in != wvra_pkg::HIT_MAX)) begin
            count_out = count_in + wvra_pkg::HIT_W'(1);
        end
    end

endmodule

FILE: sv/wvra_cfg.sv
// APB register file holding the alarm settings.
// Depends on wvra_pkg.
module wvra_cfg (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [wvra_pkg::APB_AW-1:0] paddr,
    input  logic [wvra_pkg::APB_DW-1:0] pwdata,
    output logic [wvra_pkg::APB_DW-1:0] prdata,
    output logic                        pready,
    output wvra_pkg::cfg_t              cfg
);

    wvra_pkg::cfg_t     cfg_reg, cfg_next;
    wvra_pkg::reg_idx_t idx;
    logic               wr_en;

    assign idx    = wvra_pkg::reg_idx_t'(paddr[wvra_pkg::APB_AW-1:3]);
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            unique case (idx)
                wvra_pkg::REG_LOWER:
                    cfg_next.lower_limits = pwdata[wvra_pkg::LIMITS_W-1:0];
                wvra_pkg::REG_UPPER:
                    cfg_next.upper_limits = pwdata[wvra_pkg::LIMITS_W-1:0];
                wvra_pkg::REG_PERIOD:
                    cfg_next.window_period = pwdata[wvra_pkg::PERIOD_W-1:0];
                wvra_pkg::REG_THRESH:
                    cfg_next.trigger_threshold = pwdata[wvra_pkg::THRESH_W-1:0];
                wvra_pkg::REG_DURATION:
                    cfg_next.alarm_duration = pwdata[wvra_pkg::DURATION_W-1:0];
                wvra_pkg::REG_AUTOSTOP:
                    cfg_next.auto_stop_enable = pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (idx)
            wvra_pkg::REG_LOWER:    prdata = wvra_pkg::APB_DW'(cfg_reg.lower_limits);
            wvra_pkg::REG_UPPER:    prdata = wvra_pkg::APB_DW'(cfg_reg.upper_limits);
            wvra_pkg::REG_PERIOD:   prdata = wvra_pkg::APB_DW'(cfg_reg.window_period);
            wvra_pkg::REG_THRESH:   prdata = wvra_pkg::APB_DW'(cfg_reg.trigger_threshold);
            wvra_pkg::REG_DURATION: prdata = wvra_pkg::APB_DW'(cfg_reg.alarm_duration);
            wvra_pkg::REG_AUTOSTOP: prdata = wvra_pkg::APB_DW'(cfg_reg.auto_stop_enable);
            default:                prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.lower_limits      <= '0;
            cfg_reg.upper_limits      <= '1;
            cfg_reg.window_period     <= wvra_pkg::PERIOD_W'(1);
            cfg_reg.trigger_threshold <= wvra_pkg::THRESH_W'(1);
            cfg_reg.alarm_duration    <= wvra_pkg::DURATION_W'(1);
            cfg_reg.auto_stop_enable  <= 1'b0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

FILE: tb/windowed_vibration_range_alarm_tb.sv
`timescale 1ns / 100ps
// Self-checking bench for windowed_vibration_range_alarm: directed and random sensor beats,
// APB setting changes with read-back, and a transaction-level predictor of the alarm.
// Depends on wvra_pkg and the block's RTL only.
module windowed_vibration_range_alarm_tb;

    // Longest legal quiet stretch is the deliberate receiver hold-off plus one slow beat.
    localparam int WATCHDOG_LIMIT  = 3000;
    localparam int HOLD_OFF_CYCLES = 400;
    // Back-to-back samples in one window, enough to walk a count up to the trigger.
    localparam int RUN_SAMPLES     = 20;
    localparam int RANDOM_PHASES   = 8;
    localparam int PHASE_BEATS     = 140;
    localparam int DRAIN_CYCLES    = 40;

    typedef struct packed {
        wvra_pkg::op_t op;
        logic [31:0]   now;
        logic [15:0]   mag_x;
        logic [15:0]   mag_y;
        logic [15:0]   mag_z;
    } sensor_beat_t;

    typedef struct packed {
        logic                            changed;
        logic                            alarm;
        logic [wvra_pkg::AXIS_COUNT-1:0] axes;
    } alarm_report_t;

    // ---------------------------------------------------------------- DUT signals
    logic                            aclk            = 1'b0;
    logic                            aresetn         = 1'b0;
    logic                            s_valid         = 1'b0;
    logic                            s_ready;
    logic [1:0]                      s_operation     = '0;
    logic [wvra_pkg::NOW_W-1:0]      s_now_ticks     = '0;
    logic [wvra_pkg::MAG_W-1:0]      s_magnitude_x   = '0;
    logic [wvra_pkg::MAG_W-1:0]      s_magnitude_y   = '0;
    logic [wvra_pkg::MAG_W-1:0]      s_magnitude_z   = '0;
    logic                            m_valid;
    logic                            m_ready         = 1'b0;
    logic                            m_alarm_event;
    logic                            m_alarm_on;
    logic [wvra_pkg::AXIS_COUNT-1:0] m_active_axes;
    logic                            psel            = 1'b0;
    logic                            penable         = 1'b0;
    logic                            pwrite          = 1'b0;
    logic [wvra_pkg::APB_AW-1:0]     paddr           = '0;
    logic [wvra_pkg::APB_DW-1:0]     pwdata          = '0;
    logic [wvra_pkg::APB_DW-1:0]     prdata;
    logic                            pready;

    windowed_vibration_range_alarm dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_operation     (s_operation),
        .s_now_ticks     (s_now_ticks),
        .s_magnitude_x   (s_magnitude_x),
        .s_magnitude_y   (s_magnitude_y),
        .s_magnitude_z   (s_magnitude_z),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_alarm_event   (m_alarm_event),
        .m_alarm_on      (m_alarm_on),
        .m_active_axes   (m_active_axes),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    initial begin
        forever #2 aclk = ~aclk;
    end

    // ---------------------------------------------------------------- predictor state
    // Settings as last written over APB, plus the alarm's own state.
    logic [wvra_pkg::LIMITS_W-1:0]   lower_set;
    logic [wvra_pkg::LIMITS_W-1:0]   upper_set;
    logic [wvra_pkg::PERIOD_W-1:0]   period_set;
    logic [wvra_pkg::THRESH_W-1:0]   thresh_set;
    logic [wvra_pkg::DURATION_W-1:0] duration_set;
    logic                            autostop_set;

    logic [wvra_pkg::HIT_W-1:0]      hit_cnt [wvra_pkg::AXIS_COUNT];
    logic [wvra_pkg::AXIS_COUNT-1:0] latched;
    logic                            alarm_up;
    logic [31:0]                     window_start;
    logic [31:0]                     alarm_start;

    sensor_beat_t  pending_beats[$];     // beats waiting for the driver
    alarm_report_t expected_reports[$];  // one report per accepted beat, oldest first

    // ---------------------------------------------------------------- bench bookkeeping
    int  err_count   = 0;
    int  beats_in    = 0;
    int  reports_out = 0;
    int  changes_out = 0;
    int  writes_done = 0;
    int  quiet_cycles = 0;
    bit  idle_on     = 1'b1;  // random gaps on both channels
    bit  s_taken     = 1'b0;  // input beat went through at the last rising edge
    bit  rx_taken    = 1'b0;  // result beat went through at the last rising edge
    int  hold_req    = 0;     // receiver hold-off request from the stimulus
    int  rx_hold     = 0;
    int  rx_gap      = 0;
    int  tx_gap      = 0;
    sensor_beat_t  tx_beat;
    sensor_beat_t  rx_beat;
    alarm_report_t want;

    // Window close plus auto-stop, as done at the start of tick and sample beats.
    function automatic logic close_and_expire(logic [31:0] now);
        logic [31:0] period;
        logic [31:0] elapsed;
        logic [31:0] duration;
        logic [15:0] thresh;
        logic        changed;
        logic        was_up;
        int          a;
        period   = (period_set == 0) ? 32'd1 : period_set;
        thresh   = (thresh_set == 0) ? 16'd1 : thresh_set;
        duration = (duration_set == 0) ? 32'd1 : duration_set;
        changed  = 1'b0;
        elapsed  = now - window_start;
        if (elapsed >= period) begin
            was_up = alarm_up;
            for (a = 0; a < wvra_pkg::AXIS_COUNT; a++) begin
                if (hit_cnt[a] >= thresh) begin
                    if (!latched[a])
                        changed = 1'b1;
                    latched[a] = 1'b1;
                    alarm_up   = 1'b1;
                end
                hit_cnt[a] = '0;
            end
            if (!was_up && alarm_up)
                alarm_start = now;
            // skip every whole period so the window phase is kept
            window_start = window_start + (elapsed / period) * period;
        end
        if (alarm_up && autostop_set && (now - alarm_start) >= duration) begin
            latched     = '0;
            alarm_up    = 1'b0;
            alarm_start = now;
            changed     = 1'b1;
        end
        return changed;
    endfunction

    function automatic alarm_report_t advance_alarm(sensor_beat_t b);
        alarm_report_t r;
        logic [15:0]   mag [wvra_pkg::AXIS_COUNT];
        logic [15:0]   lo;
        logic [15:0]   hi;
        int            a;
        mag[0]    = b.mag_x;
        mag[1]    = b.mag_y;
        mag[2]    = b.mag_z;
        r.changed = 1'b0;
        case (b.op)
            wvra_pkg::OP_TICK: begin
                r.changed = close_and_expire(b.now);
            end
            wvra_pkg::OP_SAMPLE: begin
                r.changed = close_and_expire(b.now);
                for (a = 0; a < wvra_pkg::AXIS_COUNT; a++) begin
                    lo = lower_set[a*wvra_pkg::MAG_W +: wvra_pkg::MAG_W];
                    hi = upper_set[a*wvra_pkg::MAG_W +: wvra_pkg::MAG_W];
                    if (lo > hi)
                        lo = hi;  // crossed limits collapse onto the upper one
                    if ((mag[a] < lo || mag[a] > hi) && hit_cnt[a] != wvra_pkg::HIT_MAX)
                        hit_cnt[a] = hit_cnt[a] + 16'd1;
                end
            end
            wvra_pkg::OP_CANCEL: begin
                r.changed = alarm_up;
                for (a = 0; a < wvra_pkg::AXIS_COUNT; a++)
                    hit_cnt[a] = '0;
                latched      = '0;
                alarm_up     = 1'b0;
                alarm_start  = b.now;
                window_start = b.now;
            end
            wvra_pkg::OP_POLICY: begin
                for (a = 0; a < wvra_pkg::AXIS_COUNT; a++)
                    hit_cnt[a] = '0;
                window_start = b.now;
                if (alarm_up && autostop_set)
                    alarm_start = b.now;
            end
            default: ;
        endcase
        r.alarm = alarm_up;
        r.axes  = latched;
        return r;
    endfunction

    // ---------------------------------------------------------------- stimulus helpers
    // Often back-to-back, as often a short gap, now and then a long one.
    function automatic int pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 45)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Used for both the window period and the alarm duration.
    function automatic logic [31:0] pick_span();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 15)
            return 32'd0;
        if (r < 30)
            return 32'd1;
        if (r < 65)
            return $urandom_range(2, 12);
        if (r < 85)
            return $urandom_range(13, 300);
        if (r < 95)
            return $urandom();
        return 32'hFFFF_FFFF;
    endfunction

    // Magnitudes cluster on the range edges so both compares flip often.
    function automatic logic [15:0] pick_mag(logic [15:0] lo, logic [15:0] hi);
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 12)
            return lo - 16'd1;
        if (r < 24)
            return lo;
        if (r < 36)
            return hi;
        if (r < 48)
            return hi + 16'd1;
        return 16'($urandom_range(0, 65535));
    endfunction

    function automatic void queue_beat(wvra_pkg::op_t op, logic [31:0] now,
                                       logic [15:0] mx, logic [15:0] my, logic [15:0] mz);
        sensor_beat_t b;
        b.op    = op;
        b.now   = now;
        b.mag_x = mx;
        b.mag_y = my;
        b.mag_z = mz;
        pending_beats.push_back(b);
    endfunction

    // APB write, then a read-back of the same register. The predictor takes
    // the new value at the write edge.
    task automatic cfg_write(wvra_pkg::reg_idx_t idx, logic [63:0] value);
        logic [63:0] readback;
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= value;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        readback = '0;
        case (idx)
            wvra_pkg::REG_LOWER: begin
                lower_set = value[wvra_pkg::LIMITS_W-1:0];
                readback  = 64'(lower_set);
            end
            wvra_pkg::REG_UPPER: begin
                upper_set = value[wvra_pkg::LIMITS_W-1:0];
                readback  = 64'(upper_set);
            end
            wvra_pkg::REG_PERIOD: begin
                period_set = value[wvra_pkg::PERIOD_W-1:0];
                readback   = 64'(period_set);
            end
            wvra_pkg::REG_THRESH: begin
                thresh_set = value[wvra_pkg::THRESH_W-1:0];
                readback   = 64'(thresh_set);
            end
            wvra_pkg::REG_DURATION: begin
                duration_set = value[wvra_pkg::DURATION_W-1:0];
                readback     = 64'(duration_set);
            end
            wvra_pkg::REG_AUTOSTOP: begin
                autostop_set = value[0];
                readback     = 64'(autostop_set);
            end
            default: ;
        endcase
        @(negedge aclk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        if (prdata !== readback) begin
            $error("prdata of register %0d: expected %0h, got %0h", idx, readback, prdata);
            err_count++;
        end
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        writes_done++;
    endtask

    task automatic load_settings(logic [47:0] lo, logic [47:0] hi, logic [31:0] per,
                                 logic [15:0] thr, logic [31:0] dur, logic auto);
        cfg_write(wvra_pkg::REG_LOWER, 64'(lo));
        cfg_write(wvra_pkg::REG_UPPER, 64'(hi));
        cfg_write(wvra_pkg::REG_PERIOD, 64'(per));
        cfg_write(wvra_pkg::REG_THRESH, 64'(thr));
        cfg_write(wvra_pkg::REG_DURATION, 64'(dur));
        cfg_write(wvra_pkg::REG_AUTOSTOP, 64'(auto));
    endtask

    // Settings only change once the block is idle: nothing queued, nothing
    // offered, every report back. Checked at the rising edge, where the
    // driver's queue and s_valid are stable.
    task automatic wait_drained();
        do @(posedge aclk);
        while (pending_beats.size() != 0 || s_valid || expected_reports.size() != 0);
        repeat (4) @(posedge aclk);
    endtask

    // ---------------------------------------------------------------- driver
    // Presents queued beats at the falling edge; a beat stays put until taken.
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (s_valid && !s_taken) begin
            // holding the current beat
        end else begin
            s_taken = 1'b0;
            if (tx_gap > 0) begin
                tx_gap--;
                s_valid <= 1'b0;
            end else if (pending_beats.size() != 0) begin
                tx_beat        = pending_beats.pop_front();
                s_valid       <= 1'b1;
                s_operation   <= tx_beat.op;
                s_now_ticks   <= tx_beat.now;
                s_magnitude_x <= tx_beat.mag_x;
                s_magnitude_y <= tx_beat.mag_y;
                s_magnitude_z <= tx_beat.mag_z;
                tx_gap         = idle_on ? pick_gap() : 0;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // ---------------------------------------------------------------- receiver
    // Random back-pressure, plus the long hold-off the stimulus asks for.
    always @(negedge aclk) begin
        if (hold_req != 0) begin
            rx_hold  = hold_req;
            hold_req = 0;
        end
        if (rx_taken) begin
            rx_taken = 1'b0;
            rx_gap   = idle_on ? pick_gap() : 0;
        end
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (rx_hold > 0) begin
            rx_hold--;
            m_ready <= 1'b0;
        end else if (rx_gap > 0) begin
            rx_gap--;
            m_ready <= 1'b0;
        end else if (idle_on && $urandom_range(0, 5) == 0) begin
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // ---------------------------------------------------------------- monitor
    // Checks result beats against the oldest prediction, then predicts for an
    // input beat taken at the same edge (its report can only come later).
    always @(posedge aclk) begin
        if (aresetn) begin
            quiet_cycles++;
            if (m_valid && m_ready) begin
                quiet_cycles = 0;
                rx_taken     = 1'b1;
                reports_out++;
                if (expected_reports.size() == 0) begin
                    $error("result beat with no report expected: event %0b alarm %0b axes %0b",
                           m_alarm_event, m_alarm_on, m_active_axes);
                    err_count++;
                end else begin
                    want = expected_reports.pop_front();
                    if (want.changed) changes_out++;
                    if (m_alarm_event !== want.changed) begin
                        $error("alarm_event: expected %0b, got %0b",
                               want.changed, m_alarm_event);
                        err_count++;
                    end
                    if (m_alarm_on !== want.alarm) begin
                        $error("alarm_on: expected %0b, got %0b", want.alarm, m_alarm_on);
                        err_count++;
                    end
                    if (m_active_axes !== want.axes) begin
                        $error("active_axes: expected %03b, got %03b", want.axes, m_active_axes);
                        err_count++;
                    end
                end
            end
            if (s_valid && s_ready) begin
                quiet_cycles  = 0;
                s_taken       = 1'b1;
                rx_beat.op    = wvra_pkg::op_t'(s_operation);
                rx_beat.now   = s_now_ticks;
                rx_beat.mag_x = s_magnitude_x;
                rx_beat.mag_y = s_magnitude_y;
                rx_beat.mag_z = s_magnitude_z;
                expected_reports.push_back(advance_alarm(rx_beat));
                beats_in++;
            end
            if (psel && penable)
                quiet_cycles = 0;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("watchdog: %0d cycles without a beat, %0d reports outstanding",
                         quiet_cycles, expected_reports.size());
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

    // ---------------------------------------------------------------- stimulus
    initial begin
        int            i;
        int            p;
        int            a;
        int unsigned   r;
        logic [31:0]   clock_now;
        logic [31:0]   t0;
        logic [31:0]   per;
        logic [31:0]   dur;
        logic [31:0]   step_max;
        logic [15:0]   thr;
        logic [47:0]   lo_lim;
        logic [47:0]   hi_lim;
        logic          auto;
        logic [15:0]   mag [wvra_pkg::AXIS_COUNT];
        wvra_pkg::op_t op;

        // Block state after reset: init at tick 0 with default settings.
        lower_set    = '0;
        upper_set    = '1;
        period_set   = 32'd1;
        thresh_set   = 16'd1;
        duration_set = 32'd1;
        autostop_set = 1'b0;
        for (a = 0; a < wvra_pkg::AXIS_COUNT; a++)
            hit_cnt[a] = '0;
        latched      = '0;
        alarm_up     = 1'b0;
        window_start = '0;
        alarm_start  = '0;

        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // --- directed: default settings accept every magnitude
        queue_beat(wvra_pkg::OP_TICK, 32'd0, 16'h0000, 16'h0000, 16'h0000);
        queue_beat(wvra_pkg::OP_SAMPLE, 32'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        wait_drained();

        // x accepts only 0xFFFF, y a band, z has crossed limits (100 over 50),
        // so only 50 is in range. Zero period, count and duration act as one.
        load_settings({16'd100, 16'h8000, 16'hFFFF}, {16'd50, 16'h9000, 16'hFFFF},
                      32'd0, 16'd0, 32'd0, 1'b1);
        // all on the edge, in range
        queue_beat(wvra_pkg::OP_SAMPLE, 32'd1, 16'hFFFF, 16'h8000, 16'd50);
        // all just outside
        queue_beat(wvra_pkg::OP_SAMPLE, 32'd1, 16'h0000, 16'h7FFF, 16'd51);
        // window closes, alarm starts
        queue_beat(wvra_pkg::OP_TICK, 32'd2, 16'h0, 16'h0, 16'h0);
        // auto-stop after one tick
        queue_beat(wvra_pkg::OP_TICK, 32'd3, 16'h0, 16'h0, 16'h0);
        queue_beat(wvra_pkg::OP_SAMPLE, 32'd3, 16'hFFFE, 16'h9001, 16'd49);
        // several windows at once
        queue_beat(wvra_pkg::OP_TICK, 32'd10, 16'h0, 16'h0, 16'h0);
        // cancel with alarm on, then with alarm off
        queue_beat(wvra_pkg::OP_CANCEL, 32'd10, 16'h0, 16'h0, 16'h0);
        queue_beat(wvra_pkg::OP_CANCEL, 32'd11, 16'h0, 16'h0, 16'h0);
        queue_beat(wvra_pkg::OP_SAMPLE, 32'd11, 16'h0, 16'h0, 16'h0);
        // drops the pending hits
        queue_beat(wvra_pkg::OP_POLICY, 32'd11, 16'h0, 16'h0, 16'h0);
        queue_beat(wvra_pkg::OP_TICK, 32'd12, 16'h0, 16'h0, 16'h0);
        // x only
        queue_beat(wvra_pkg::OP_SAMPLE, 32'd12, 16'h0, 16'h8500, 16'd50);
        queue_beat(wvra_pkg::OP_TICK, 32'd13, 16'h0, 16'h0, 16'h0);
        // restarts the alarm timer
        queue_beat(wvra_pkg::OP_POLICY, 32'd14, 16'h0, 16'h0, 16'h0);
        queue_beat(wvra_pkg::OP_TICK, 32'd14, 16'h0, 16'h0, 16'h0);
        queue_beat(wvra_pkg::OP_TICK, 32'd15, 16'h0, 16'h0, 16'h0);
        queue_beat(wvra_pkg::OP_CANCEL, 32'hFFFF_FFFF, 16'h0, 16'h0, 16'h0);
        queue_beat(wvra_pkg::OP_SAMPLE, 32'hFFFF_FFFF, 16'h1234, 16'hFFFF, 16'hFFFF);
        // elapsed wraps through zero
        queue_beat(wvra_pkg::OP_TICK, 32'd0, 16'h0, 16'h0, 16'h0);
        wait_drained();

        // --- trigger count edge, period and duration at their top values, no
        // idling. Every nonzero magnitude is out of range (limits cross down
        // to 0). x passes the trigger count, z lands on it exactly and y is
        // one short, so at the window close x and z latch and y does not.
        idle_on = 1'b0;
        load_settings(48'hFFFF_FFFF_FFFF, 48'h0, 32'hFFFF_FFFF, 16'(RUN_SAMPLES - 5),
                      32'hFFFF_FFFF, 1'b1);
        t0 = 32'h8000_0000;
        queue_beat(wvra_pkg::OP_CANCEL, t0, 16'h0, 16'h0, 16'h0);
        for (i = 0; i < RUN_SAMPLES; i++)
            queue_beat(wvra_pkg::OP_SAMPLE, t0, 16'($urandom_range(1, 65535)),
                       (i < 6) ? 16'h0 : 16'($urandom_range(1, 65535)),
                       (i < 5) ? 16'h0 : 16'($urandom_range(1, 65535)));
        // one full period later
        queue_beat(wvra_pkg::OP_TICK, t0 - 32'd1, 16'h0, 16'h0, 16'h0);
        // full duration: auto-stop
        queue_beat(wvra_pkg::OP_TICK, t0 - 32'd2, 16'h0, 16'h0, 16'h0);
        wait_drained();
        idle_on = 1'b1;

        // --- random phases, a fresh setting each
        clock_now = 32'd0;
        for (p = 0; p < RANDOM_PHASES; p++) begin
            for (a = 0; a < wvra_pkg::AXIS_COUNT; a++) begin
                r = $urandom_range(0, 99);
                lo_lim[a*wvra_pkg::MAG_W +: wvra_pkg::MAG_W] =
                    (r < 15) ? 16'h0000 : 16'($urandom_range(0, 65535));
                r = $urandom_range(0, 99);
                hi_lim[a*wvra_pkg::MAG_W +: wvra_pkg::MAG_W] =
                    (r < 15) ? 16'hFFFF : 16'($urandom_range(0, 65535));
            end
            per = pick_span();
            dur = pick_span();
            r   = $urandom_range(0, 99);
            if (r < 15)
                thr = 16'd0;
            else if (r < 55)
                thr = 16'($urandom_range(1, 3));
            else if (r < 85)
                thr = 16'($urandom_range(4, 20));
            else if (r < 95)
                thr = 16'($urandom_range(0, 65535));
            else
                thr = 16'hFFFF;
            auto = 1'($urandom_range(0, 1));
            // first phases pin the smallest settings
            if (p == 0) begin
                per  = 32'd1;
                thr  = 16'd1;
                dur  = 32'd1;
                auto = 1'b1;
            end else if (p == 1) begin
                per = 32'd0;
                thr = 16'd0;
                dur = 32'd0;
            end
            load_settings(lo_lim, hi_lim, per, thr, dur, auto);

            idle_on = (p != 3);  // one phase runs flat out on both sides
            if (p == 2)
                hold_req = HOLD_OFF_CYCLES;  // results back up, s_ready must drop
            if ($urandom_range(0, 3) == 0)
                clock_now = 32'hFFFF_FFFF - 32'($urandom_range(0, 300));

            step_max = (per != 0 && per <= 64) ? per : 32'd64;
            for (i = 0; i < PHASE_BEATS; i++) begin
                r = $urandom_range(0, 99);
                if (r < 4)
                    clock_now = $urandom();  // arbitrary jump, backward too
                else if (r < 20)
                    clock_now = clock_now + $urandom_range(0, 4 * step_max);
                else
                    clock_now = clock_now + $urandom_range(0, step_max);
                r = $urandom_range(0, 99);
                if (r < 55)
                    op = wvra_pkg::OP_SAMPLE;
                else if (r < 80)
                    op = wvra_pkg::OP_TICK;
                else if (r < 92)
                    op = wvra_pkg::OP_POLICY;
                else
                    op = wvra_pkg::OP_CANCEL;
                for (a = 0; a < wvra_pkg::AXIS_COUNT; a++)
                    mag[a] = pick_mag(lo_lim[a*wvra_pkg::MAG_W +: wvra_pkg::MAG_W],
                                      hi_lim[a*wvra_pkg::MAG_W +: wvra_pkg::MAG_W]);
                queue_beat(op, clock_now, mag[0], mag[1], mag[2]);
            end
            wait_drained();
        end

        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("covered %0d sensor beats, %0d reports (%0d with a state change)",
                 beats_in, reports_out, changes_out);
        $display("across %0d register writes, the trigger count edge and tick wraparound",
                 writes_done);
        if (err_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
